/* hdl/pirc_pkg.sv */
// Shared types, constants and the test micro-program for the point-in-region classifier.
`default_nettype none
package pirc_pkg;

    localparam int MAX_REGIONS = 32;
    localparam int NVAL        = 8;
    localparam int VAL_W       = 32;
    localparam int IDX_W       = $clog2(MAX_REGIONS);
    localparam int CNT_W       = $clog2(MAX_REGIONS + 1);
    localparam int WORD_W      = $clog2(NVAL);
    localparam int ADDR_W      = IDX_W + WORD_W;
    localparam int MEM_DEPTH   = MAX_REGIONS * NVAL;
    localparam int LIMB_W      = 32;
    localparam int OPND_LIMBS  = 5;
    localparam int OPND_W      = OPND_LIMBS * LIMB_W;
    localparam int LCNT_W      = 3;
    localparam int PROD_W      = 224;
    localparam int ACC_W       = 72;
    localparam int RAD_W       = 104;
    localparam int X_W         = 144;
    localparam int PC_W        = 5;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_TEST  = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        KIND_SPHERE = 2'd0,
        KIND_BOX    = 2'd1,
        KIND_CONE   = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_WRITE,
        ST_FETCH,
        ST_EVAL,
        ST_ISSUE,
        ST_WAIT,
        ST_STEP,
        ST_DONE
    } state_t;

    // multiplier operand sources
    typedef enum logic [3:0] {
        SRC_E0, SRC_E1, SRC_E2,
        SRC_Q0, SRC_Q1, SRC_Q2,
        SRC_R0, SRC_R1,
        SRC_L, SRC_P, SRC_T, SRC_LMT, SRC_X, SRC_R
    } src_t;

    typedef enum logic [2:0] {
        DST_L, DST_P, DST_T, DST_X, DST_R, DST_W1, DST_W2
    } dst_t;

    typedef enum logic [1:0] {
        MODE_SET, MODE_ADD, MODE_SUB
    } mode_t;

    typedef struct packed {
        src_t  a;
        src_t  b;
        dst_t  dst;
        mode_t mode;
    } uop_t;

    localparam logic [PC_W-1:0] PC_SPH_START  = PC_W'(0);
    localparam logic [PC_W-1:0] PC_SPH_END    = PC_W'(3);
    localparam logic [PC_W-1:0] PC_CONE_START = PC_W'(4);
    localparam logic [PC_W-1:0] PC_CONE_CHK   = PC_W'(12);
    localparam logic [PC_W-1:0] PC_CONE_END   = PC_W'(18);

    typedef struct packed {
        logic [1:0]                  operation;
        logic [1:0]                  region_kind;
        logic [NVAL-1:0][VAL_W-1:0]  value;
        logic [31:0]                 point_tag;
    } item_t;

    typedef struct packed {
        logic              item_load;
        logic              wr_en;
        logic              rd_en;
        logic              mirror;
        logic [1:0]        axis;
        logic [IDX_W-1:0]  idx;
        logic [WORD_W-1:0] word;
        logic              kind_we;
        logic              mul_start;
        uop_t              uop;
        logic              out_load;
        logic              out_hit;
        logic              out_ovf;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic [1:0] kind;
        logic       load_ok;
        logic [1:0] ent_kind;
        logic       box_hit;
        logic       sph_hit;
        logic       cone_reject;
        logic       cone_hit;
        logic       mul_done;
    } stat_t;

    // sphere: P = |d|^2, W2 = r^2
    // cone: L = |e|^2, P = |q|^2, T = q.e, X = P*L - T^2, W1 = L*X,
    //       R = r0*(L-T) + r1*T, W2 = R^2
    function automatic uop_t prog(input logic [PC_W-1:0] pc);
        uop_t u;
        unique case (pc)
            5'd0:    u = '{SRC_Q0, SRC_Q0, DST_P, MODE_SET};
            5'd1:    u = '{SRC_Q1, SRC_Q1, DST_P, MODE_ADD};
            5'd2:    u = '{SRC_Q2, SRC_Q2, DST_P, MODE_ADD};
            5'd3:    u = '{SRC_R0, SRC_R0, DST_W2, MODE_SET};
            5'd4:    u = '{SRC_E0, SRC_E0, DST_L, MODE_SET};
            5'd5:    u = '{SRC_E1, SRC_E1, DST_L, MODE_ADD};
            5'd6:    u = '{SRC_E2, SRC_E2, DST_L, MODE_ADD};
            5'd7:    u = '{SRC_Q0, SRC_Q0, DST_P, MODE_SET};
            5'd8:    u = '{SRC_Q1, SRC_Q1, DST_P, MODE_ADD};
            5'd9:    u = '{SRC_Q2, SRC_Q2, DST_P, MODE_ADD};
            5'd10:   u = '{SRC_E0, SRC_Q0, DST_T, MODE_SET};
            5'd11:   u = '{SRC_E1, SRC_Q1, DST_T, MODE_ADD};
            5'd12:   u = '{SRC_E2, SRC_Q2, DST_T, MODE_ADD};
            5'd13:   u = '{SRC_P, SRC_L, DST_X, MODE_SET};
            5'd14:   u = '{SRC_T, SRC_T, DST_X, MODE_SUB};
            5'd15:   u = '{SRC_L, SRC_X, DST_W1, MODE_SET};
            5'd16:   u = '{SRC_R0, SRC_LMT, DST_R, MODE_SET};
            5'd17:   u = '{SRC_R1, SRC_T, DST_R, MODE_ADD};
            5'd18:   u = '{SRC_R, SRC_R, DST_W2, MODE_SET};
            default: u = '{SRC_Q0, SRC_Q0, DST_P, MODE_SET};
        endcase
        return u;
    endfunction

    // number of 32-bit limbs each operand can occupy
    function automatic logic [LCNT_W-1:0] src_limbs(input src_t s);
        logic [LCNT_W-1:0] n;
        unique case (s)
            SRC_L, SRC_P, SRC_T, SRC_LMT: n = LCNT_W'(3);
            SRC_X:                        n = LCNT_W'(5);
            SRC_R:                        n = LCNT_W'(4);
            default:                      n = LCNT_W'(1);
        endcase
        return n;
    endfunction

endpackage
`default_nettype wire

/* hdl/pirc_if.sv */
// Valid/ready channel interfaces for point items and test results.
`default_nettype none
interface pirc_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic [1:0]         region_kind;
    logic signed [31:0] value_0;
    logic signed [31:0] value_1;
    logic signed [31:0] value_2;
    logic signed [31:0] value_3;
    logic signed [31:0] value_4;
    logic signed [31:0] value_5;
    logic signed [31:0] value_6;
    logic signed [31:0] value_7;
    logic [31:0]        point_tag;

    modport source (
        output valid, operation, region_kind, value_0, value_1, value_2, value_3,
               value_4, value_5, value_6, value_7, point_tag,
        input  ready
    );
    modport sink (
        input  valid, operation, region_kind, value_0, value_1, value_2, value_3,
               value_4, value_5, value_6, value_7, point_tag,
        output ready
    );
endinterface

interface pirc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] tag_out;
    logic        in_region;
    logic        table_overflow;

    modport source (output valid, tag_out, in_region, table_overflow, input ready);
    modport sink (input valid, tag_out, in_region, table_overflow, output ready);
endinterface
`default_nettype wire

/* hdl/pirc_datapath.sv */
// Region table storage, shared limb multiplier, accumulators and match compares.
`default_nettype none
module pirc_datapath (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire pirc_pkg::item_t item,
    input  wire pirc_pkg::cmd_t  cmd,
    output pirc_pkg::stat_t      stat,
    output logic [31:0]          tag_out,
    output logic                 in_region,
    output logic                 table_overflow
);
    import pirc_pkg::*;

    localparam logic [VAL_W-1:0] VMIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic [VAL_W-1:0] VMAX = {1'b0, {(VAL_W-1){1'b1}}};

    logic [1:0]       op_reg;
    logic [1:0]       kind_reg;
    logic [VAL_W-1:0] item_v [NVAL];
    logic [31:0]      tag_reg;

    logic [VAL_W-1:0] mem [MEM_DEPTH];
    logic [1:0]       kind_mem [MAX_REGIONS];
    logic [VAL_W-1:0] ent_v [NVAL];
    logic [1:0]       ent_kind_reg;

    logic [VAL_W-1:0]  wr_data;
    logic [WORD_W-1:0] ax;

    logic [ACC_W-1:0] l_reg, p_reg, t_reg;
    logic [X_W-1:0]   x_reg;
    logic [RAD_W-1:0] r_reg;
    logic [PROD_W-1:0] w1_reg, w2_reg;

    logic               run_reg, pp_vld_reg, pp_last_reg, wb_reg, sgn_reg;
    logic [LCNT_W-1:0]  ia_reg, jb_reg, pp_sh_reg;
    logic [2*LIMB_W-1:0] pp_reg;
    logic [PROD_W-1:0]  prod_reg;

    logic [OPND_W-1:0] a_bus, b_bus;
    logic              a_sgn, b_sgn;
    logic [LCNT_W-1:0] na, nb;
    logic [LIMB_W-1:0] a_limb, b_limb;
    logic              pp_last;
    logic [PROD_W-1:0] pp_shifted;
    logic [PROD_W:0]   sprod;
    logic [ACC_W-1:0]  lmt;

    function automatic logic [VAL_W-1:0] sat_neg(input logic [VAL_W-1:0] v);
        return (v == VMIN) ? VMAX : VAL_W'(-v);
    endfunction

    // signed difference a-b, returned as {sign, magnitude}
    function automatic logic [VAL_W:0] diff_mag(input logic [VAL_W-1:0] a,
                                                input logic [VAL_W-1:0] b);
        logic [VAL_W:0] d;
        d = {a[VAL_W-1], a} - {b[VAL_W-1], b};
        return d[VAL_W] ? {1'b1, VAL_W'(-d)} : {1'b0, d[VAL_W-1:0]};
    endfunction

    function automatic logic [VAL_W-1:0] abs_v(input logic [VAL_W-1:0] v);
        return v[VAL_W-1] ? VAL_W'(-v) : v;
    endfunction

    function automatic logic [OPND_W:0] opnd(input src_t s);
        logic [VAL_W:0] dm;
        logic [OPND_W:0] o;
        dm = '0;
        unique case (s)
            SRC_E0:  dm = diff_mag(ent_v[4], ent_v[0]);
            SRC_E1:  dm = diff_mag(ent_v[5], ent_v[1]);
            SRC_E2:  dm = diff_mag(ent_v[6], ent_v[2]);
            SRC_Q0:  dm = diff_mag(item_v[0], ent_v[0]);
            SRC_Q1:  dm = diff_mag(item_v[1], ent_v[1]);
            SRC_Q2:  dm = diff_mag(item_v[2], ent_v[2]);
            SRC_R0:  dm = {1'b0, abs_v(ent_v[3])};
            SRC_R1:  dm = {1'b0, abs_v(ent_v[7])};
            default: dm = '0;
        endcase
        unique case (s)
            SRC_L:   o = {1'b0, OPND_W'(l_reg)};
            SRC_P:   o = {1'b0, OPND_W'(p_reg)};
            SRC_T:   o = {1'b0, OPND_W'(t_reg)};
            SRC_LMT: o = {1'b0, OPND_W'(lmt)};
            SRC_X:   o = {1'b0, OPND_W'(x_reg)};
            SRC_R:   o = {1'b0, OPND_W'(r_reg)};
            default: o = {dm[VAL_W], OPND_W'(dm[VAL_W-1:0])};
        endcase
        return o;
    endfunction

    // item capture
    always_ff @(posedge clk)
    begin
        if (cmd.item_load)
        begin
            op_reg   <= item.operation;
            kind_reg <= item.region_kind;
            tag_reg  <= item.point_tag;
            for (int k = 0; k < NVAL; k++)
            begin
                item_v[k] <= item.value[k];
            end
        end
    end

    // mirrored copy flips the chosen axis
    always_comb
    begin
        ax      = WORD_W'(cmd.axis) - WORD_W'(1);
        wr_data = item_v[cmd.word];
        if (cmd.mirror)
        begin
            unique case (kind_reg)
                KIND_BOX:
                begin
                    if (cmd.word == ax)
                        wr_data = sat_neg(item_v[ax + WORD_W'(3)]);
                    else if (cmd.word == ax + WORD_W'(3))
                        wr_data = sat_neg(item_v[ax]);
                end
                KIND_CONE:
                begin
                    if (cmd.word == ax || cmd.word == ax + WORD_W'(4))
                        wr_data = sat_neg(item_v[cmd.word]);
                end
                default:
                begin
                    if (cmd.word == ax)
                        wr_data = sat_neg(item_v[cmd.word]);
                end
            endcase
        end
    end

    // table memory and entry fetch
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
            mem[{cmd.idx, cmd.word}] <= wr_data;
        if (cmd.kind_we)
            kind_mem[cmd.idx] <= kind_reg;
        if (cmd.rd_en)
        begin
            ent_v[cmd.word] <= mem[{cmd.idx, cmd.word}];
            ent_kind_reg    <= kind_mem[cmd.idx];
        end
    end

    // shared multiplier: one 32x32 limb product per cycle, then accumulate
    always_comb
    begin
        {a_sgn, a_bus} = opnd(cmd.uop.a);
        {b_sgn, b_bus} = opnd(cmd.uop.b);
        na         = src_limbs(cmd.uop.a);
        nb         = src_limbs(cmd.uop.b);
        a_limb     = a_bus[ia_reg*LIMB_W +: LIMB_W];
        b_limb     = b_bus[jb_reg*LIMB_W +: LIMB_W];
        pp_last    = (ia_reg == na - LCNT_W'(1)) && (jb_reg == nb - LCNT_W'(1));
        pp_shifted = PROD_W'(pp_reg) << {pp_sh_reg, 5'b0};
        sprod      = sgn_reg ? (PROD_W+1)'(0) - {1'b0, prod_reg} : {1'b0, prod_reg};
        lmt        = l_reg - t_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg     <= 1'b0;
            pp_vld_reg  <= 1'b0;
            pp_last_reg <= 1'b0;
            wb_reg      <= 1'b0;
        end
        else
        begin
            pp_vld_reg  <= run_reg;
            pp_last_reg <= run_reg && pp_last;
            wb_reg      <= pp_vld_reg && pp_last_reg;
            if (cmd.mul_start)
                run_reg <= 1'b1;
            else if (run_reg && pp_last)
                run_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_start)
        begin
            ia_reg   <= '0;
            jb_reg   <= '0;
            prod_reg <= '0;
            sgn_reg  <= a_sgn ^ b_sgn;
        end
        else
        begin
            if (run_reg)
            begin
                pp_reg    <= a_limb * b_limb;
                pp_sh_reg <= ia_reg + jb_reg;
                if (jb_reg == nb - LCNT_W'(1))
                begin
                    jb_reg <= '0;
                    ia_reg <= ia_reg + LCNT_W'(1);
                end
                else
                begin
                    jb_reg <= jb_reg + LCNT_W'(1);
                end
            end
            if (pp_vld_reg)
                prod_reg <= prod_reg + pp_shifted;
        end
    end

    // write-back into the selected accumulator
    always_ff @(posedge clk)
    begin
        if (wb_reg)
        begin
            unique case (cmd.uop.dst)
                DST_L:
                    unique case (cmd.uop.mode)
                        MODE_ADD: l_reg <= l_reg + ACC_W'(sprod);
                        MODE_SUB: l_reg <= l_reg - ACC_W'(sprod);
                        default:  l_reg <= ACC_W'(sprod);
                    endcase
                DST_P:
                    unique case (cmd.uop.mode)
                        MODE_ADD: p_reg <= p_reg + ACC_W'(sprod);
                        MODE_SUB: p_reg <= p_reg - ACC_W'(sprod);
                        default:  p_reg <= ACC_W'(sprod);
                    endcase
                DST_T:
                    unique case (cmd.uop.mode)
                        MODE_ADD: t_reg <= t_reg + ACC_W'(sprod);
                        MODE_SUB: t_reg <= t_reg - ACC_W'(sprod);
                        default:  t_reg <= ACC_W'(sprod);
                    endcase
                DST_X:
                    unique case (cmd.uop.mode)
                        MODE_ADD: x_reg <= x_reg + X_W'(sprod);
                        MODE_SUB: x_reg <= x_reg - X_W'(sprod);
                        default:  x_reg <= X_W'(sprod);
                    endcase
                DST_R:
                    unique case (cmd.uop.mode)
                        MODE_ADD: r_reg <= r_reg + RAD_W'(sprod);
                        MODE_SUB: r_reg <= r_reg - RAD_W'(sprod);
                        default:  r_reg <= RAD_W'(sprod);
                    endcase
                DST_W1:
                    w1_reg <= PROD_W'(sprod);
                default:
                    w2_reg <= PROD_W'(sprod);
            endcase
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            tag_out        <= tag_reg;
            in_region      <= cmd.out_hit;
            table_overflow <= cmd.out_ovf;
        end
    end

    always_comb
    begin
        stat.op       = op_reg;
        stat.kind     = kind_reg;
        stat.ent_kind = ent_kind_reg;
        stat.mul_done = wb_reg;
        unique case (kind_reg)
            KIND_SPHERE: stat.load_ok = !item_v[3][VAL_W-1] && (item_v[3] != '0);
            KIND_BOX:    stat.load_ok = $signed(item_v[0]) < $signed(item_v[3]);
            KIND_CONE:   stat.load_ok = !item_v[3][VAL_W-1] && !item_v[7][VAL_W-1];
            default:     stat.load_ok = 1'b0;
        endcase
        stat.box_hit = $signed(item_v[0]) >= $signed(ent_v[0])
                    && $signed(item_v[0]) <= $signed(ent_v[3])
                    && $signed(item_v[1]) >= $signed(ent_v[1])
                    && $signed(item_v[1]) <= $signed(ent_v[4])
                    && $signed(item_v[2]) >= $signed(ent_v[2])
                    && $signed(item_v[2]) <= $signed(ent_v[5]);
        stat.sph_hit     = PROD_W'(p_reg) <= w2_reg;
        stat.cone_reject = (l_reg == '0) || t_reg[ACC_W-1]
                        || ($signed(t_reg) > $signed(l_reg));
        stat.cone_hit    = w1_reg < w2_reg;
    end

endmodule
`default_nettype wire

/* hdl/pirc_ctrl.sv */
// Sequencer: loads, clears, table walk and micro-program stepping for tests.
`default_nettype none
module pirc_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  wire logic            out_ready,
    input  wire logic            cfg_we,
    input  wire logic [1:0]      cfg_wdata,
    input  wire pirc_pkg::stat_t stat,
    output pirc_pkg::cmd_t       cmd
);
    import pirc_pkg::*;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_REGIONS);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              ovf_reg, ovf_next;
    logic [1:0]        mirror_reg;
    logic [WORD_W-1:0] word_reg, word_next;
    logic              mpass_reg, mpass_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [PC_W-1:0]   pc_reg, pc_next;
    logic              hit_reg, hit_next;
    logic              out_valid_reg, out_valid_next;
    logic              last_entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            mirror_reg    <= '0;
            word_reg      <= '0;
            mpass_reg     <= 1'b0;
            idx_reg       <= '0;
            pc_reg        <= '0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            word_reg      <= word_next;
            mpass_reg     <= mpass_next;
            idx_reg       <= idx_next;
            pc_reg        <= pc_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                mirror_reg <= cfg_wdata;
        end
    end

    assign last_entry = (CNT_W'(idx_reg) == count_reg - CNT_W'(1));
    assign out_valid  = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        word_next      = word_reg;
        mpass_next     = mpass_reg;
        idx_next       = idx_reg;
        pc_next        = pc_reg;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;

        cmd           = '0;
        cmd.mirror    = mpass_reg;
        cmd.axis      = mirror_reg;
        cmd.word      = word_reg;
        cmd.idx       = idx_reg;
        cmd.uop       = prog(pc_reg);
        cmd.out_hit   = hit_reg;
        cmd.out_ovf   = ovf_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.item_load = 1'b1;
                    state_next    = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                unique case (stat.op)
                    OP_LOAD:
                    begin
                        if (!stat.load_ok)
                            state_next = ST_IDLE;
                        else if (count_reg == CNT_MAX)
                        begin
                            ovf_next   = 1'b1;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            word_next  = '0;
                            mpass_next = 1'b0;
                            state_next = ST_WRITE;
                        end
                    end
                    OP_TEST:
                    begin
                        hit_next  = 1'b0;
                        idx_next  = '0;
                        word_next = '0;
                        state_next = (count_reg == '0) ? ST_DONE : ST_FETCH;
                    end
                    OP_CLEAR:
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_IDLE;
                    end
                    default:
                        state_next = ST_IDLE;
                endcase
            end
            ST_WRITE:
            begin
                cmd.wr_en = 1'b1;
                cmd.idx   = count_reg[IDX_W-1:0];
                word_next = word_reg + WORD_W'(1);
                if (word_reg == WORD_W'(NVAL - 1))
                begin
                    cmd.kind_we = 1'b1;
                    count_next  = count_reg + CNT_W'(1);
                    if (!mpass_reg && mirror_reg != 2'd0)
                    begin
                        if (count_reg + CNT_W'(1) == CNT_MAX)
                        begin
                            ovf_next   = 1'b1;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            mpass_next = 1'b1;
                        end
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FETCH:
            begin
                cmd.rd_en = 1'b1;
                word_next = word_reg + WORD_W'(1);
                if (word_reg == WORD_W'(NVAL - 1))
                    state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                unique case (stat.ent_kind)
                    KIND_SPHERE:
                    begin
                        pc_next    = PC_SPH_START;
                        state_next = ST_ISSUE;
                    end
                    KIND_CONE:
                    begin
                        pc_next    = PC_CONE_START;
                        state_next = ST_ISSUE;
                    end
                    default:
                    begin
                        hit_next = hit_reg || stat.box_hit;
                        if (hit_next || last_entry)
                            state_next = ST_DONE;
                        else
                        begin
                            idx_next   = idx_reg + IDX_W'(1);
                            state_next = ST_FETCH;
                        end
                    end
                endcase
            end
            ST_ISSUE:
            begin
                cmd.mul_start = 1'b1;
                state_next    = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (stat.mul_done)
                    state_next = ST_STEP;
            end
            ST_STEP:
            begin
                priority if (pc_reg == PC_SPH_END || pc_reg == PC_CONE_END
                             || (pc_reg == PC_CONE_CHK && stat.cone_reject))
                begin
                    if (pc_reg == PC_SPH_END)
                        hit_next = hit_reg || stat.sph_hit;
                    else if (pc_reg == PC_CONE_END)
                        hit_next = hit_reg || stat.cone_hit;
                    if (hit_next || last_entry)
                        state_next = ST_DONE;
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        word_next  = '0;
                        state_next = ST_FETCH;
                    end
                end
                else
                begin
                    pc_next    = pc_reg + PC_W'(1);
                    state_next = ST_ISSUE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX)
        else $error("region count past table size");
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        stat.mul_done |-> state_reg == ST_WAIT)
        else $error("multiply finished outside wait state");
    a_out_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before taken");
    a_write_below_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_en |-> count_reg < CNT_MAX)
        else $error("table write while full");
`endif

endmodule
`default_nettype wire

/* hdl/point_in_region_classifier_top.sv */
// Top level of the point-in-region classifier: controller, datapath and channels.
`default_nettype none
// Holds up to 32 regions (spheres, boxes, cones) in a 256-word table memory and
// answers point tests with one result transaction each; loads, clears and unknown
// operations give no result. A load makes 8 memory writes per stored copy. A test
// walks the stored entries one at a time: each entry is fetched word by word from
// the single-port table memory and then decoded, which also decides a box. A
// sphere then runs 4 single-limb products through the shared 32x32 limb multiplier.
// A cone runs up to 15 products, and only the first 9 when its axis test rejects
// it. The walk stops at the first matching entry. The cost of a test per entry
// visited is set by the one shared multiplier and the one memory read port.
// A finished result waits in an output register; the next item is taken while
// it waits. The symmetry register may be written only while the block is idle.
module point_in_region_classifier_top (
    input  wire logic       clk,
    input  wire logic       rst_n,
    pirc_in_if.sink         req,
    pirc_out_if.source      rsp,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_wdata
);
    import pirc_pkg::*;

    item_t item;
    cmd_t  cmd;
    stat_t stat;

    // pack the incoming transaction for the datapath capture register
    always_comb
    begin
        item.operation   = req.operation;
        item.region_kind = req.region_kind;
        item.value[0]    = req.value_0;
        item.value[1]    = req.value_1;
        item.value[2]    = req.value_2;
        item.value[3]    = req.value_3;
        item.value[4]    = req.value_4;
        item.value[5]    = req.value_5;
        item.value[6]    = req.value_6;
        item.value[7]    = req.value_7;
        item.point_tag   = req.point_tag;
    end

    pirc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .stat      (stat),
        .cmd       (cmd)
    );

    pirc_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .item           (item),
        .cmd            (cmd),
        .stat           (stat),
        .tag_out        (rsp.tag_out),
        .in_region      (rsp.in_region),
        .table_overflow (rsp.table_overflow)
    );

endmodule
`default_nettype wire

/* test/tb_point_in_region_classifier_top.sv */
// Self-checking testbench for the point-in-region classifier top level.
`default_nettype none
module tb_point_in_region_classifier_top;
    timeunit 1ns;
    timeprecision 1ps;
    import pirc_pkg::*;

    // Timeout in cycles: the cost of a miss against a full table of cones, times
    // about 400 transactions plus both sides' longest gaps, then taken a few times
    // over.
    localparam int CYCLE_LIMIT = 8_000_000;
    localparam int MAX_SHOWN   = 10;
    localparam int SETTLE      = 200;
    localparam longint ONE     = 64'sd65536;         // 1.0 in Q16.16
    localparam longint CMAX    = 64'sd2147483647;
    localparam longint CMIN    = -64'sd2147483648;

    typedef struct {
        logic [31:0] tag;
        logic        hit;
        logic        ovf;
    } verdict_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_wdata = 2'd0;

    pirc_in_if  req_ch ();
    pirc_out_if rsp_ch ();

    point_in_region_classifier_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #1 clk = ~clk;

    // ---------------------------------------------------------------------
    // Region table shadow: what the block should hold after each transaction
    // ---------------------------------------------------------------------
    logic [1:0]          shadow_kind [MAX_REGIONS];
    logic signed [63:0]  shadow_val  [MAX_REGIONS][NVAL];
    int unsigned         shadow_count = 0;
    logic                shadow_ovf = 1'b0;
    logic [1:0]          shadow_axis = 2'd0;

    verdict_t            expected_verdicts[$];
    item_t               pending_items[$];

    int unsigned errors = 0;
    int unsigned n_tests = 0, n_hits = 0, n_loads = 0, n_ovf_seen = 0;
    longint unsigned cycles = 0;

    function automatic logic [255:0] magn(input logic signed [63:0] d);
        return (d < 0) ? 256'(-d) : 256'(d);
    endfunction

    function automatic logic signed [63:0] neg_sat(input logic signed [63:0] v);
        return (v == CMIN) ? CMAX : -v;
    endfunction

    function automatic logic sphere_covers(input int unsigned n,
                                           input logic signed [63:0] p [3]);
        logic [255:0] s;
        s = 0;
        for (int k = 0; k < 3; k++)
            s += magn(p[k] - shadow_val[n][k]) * magn(p[k] - shadow_val[n][k]);
        return s <= magn(shadow_val[n][3]) * magn(shadow_val[n][3]);
    endfunction

    function automatic logic box_covers(input int unsigned n,
                                        input logic signed [63:0] p [3]);
        logic ok;
        ok = 1'b1;
        for (int k = 0; k < 3; k++)
            if (p[k] < shadow_val[n][k] || p[k] > shadow_val[n][k+3]) ok = 1'b0;
        return ok;
    endfunction

    // Squared projection test: axis e, offset q, t = q.e, no roots anywhere.
    function automatic logic cone_covers(input int unsigned n,
                                         input logic signed [63:0] p [3]);
        logic [255:0] len2, dist2, pos, neg, t, lhs, rad;
        logic signed [63:0] e, q;
        len2 = 0; dist2 = 0; pos = 0; neg = 0;
        for (int k = 0; k < 3; k++)
        begin
            e = shadow_val[n][4+k] - shadow_val[n][k];
            q = p[k] - shadow_val[n][k];
            len2 += magn(e) * magn(e);
            dist2 += magn(q) * magn(q);
            if ((e < 0) != (q < 0)) neg += magn(e) * magn(q);
            else pos += magn(e) * magn(q);
        end
        if (len2 == 0 || pos < neg) return 1'b0;     // zero height or behind apex
        t = pos - neg;
        if (t > len2) return 1'b0;
        lhs = len2 * (dist2 * len2 - t * t);
        rad = magn(shadow_val[n][3]) * (len2 - t) + magn(shadow_val[n][7]) * t;
        return lhs < rad * rad;
    endfunction

    function automatic void store_region(input logic [1:0] kind,
                                         input logic signed [63:0] v [NVAL]);
        if (shadow_count >= MAX_REGIONS)
        begin
            shadow_ovf = 1'b1;
            return;
        end
        shadow_kind[shadow_count] = kind;
        for (int k = 0; k < NVAL; k++) shadow_val[shadow_count][k] = v[k];
        shadow_count++;
    endfunction

    // Apply one accepted transaction to the shadow and queue its verdict.
    function automatic void classify_item(input item_t it);
        logic signed [63:0] v [NVAL];
        logic signed [63:0] m [NVAL];
        logic signed [63:0] p [3];
        logic ok, hit;
        int ax;
        verdict_t vd;
        for (int k = 0; k < NVAL; k++) v[k] = 64'(signed'(it.value[k]));
        case (it.operation)
            OP_LOAD:
            begin
                case (it.region_kind)
                    KIND_SPHERE: ok = v[3] > 0;
                    KIND_BOX:    ok = v[0] < v[3];
                    KIND_CONE:   ok = v[3] >= 0 && v[7] >= 0;
                    default:     ok = 1'b0;
                endcase
                if (ok)
                begin
                    n_loads++;
                    store_region(it.region_kind, v);
                    if (shadow_axis != 2'd0)
                    begin
                        ax = shadow_axis - 1;
                        m = v;
                        if (it.region_kind == KIND_BOX)
                        begin
                            m[ax] = neg_sat(v[ax+3]);
                            m[ax+3] = neg_sat(v[ax]);
                        end
                        else
                        begin
                            m[ax] = neg_sat(v[ax]);
                            if (it.region_kind == KIND_CONE) m[ax+4] = neg_sat(v[ax+4]);
                        end
                        store_region(it.region_kind, m);
                    end
                end
            end
            OP_CLEAR:
            begin
                shadow_count = 0;
                shadow_ovf = 1'b0;
            end
            OP_TEST:
            begin
                for (int k = 0; k < 3; k++) p[k] = v[k];
                hit = 1'b0;
                for (int unsigned n = 0; n < shadow_count; n++)
                    case (shadow_kind[n])
                        KIND_SPHERE: hit |= sphere_covers(n, p);
                        KIND_BOX:    hit |= box_covers(n, p);
                        default:     hit |= cone_covers(n, p);
                    endcase
                vd.tag = it.point_tag;
                vd.hit = hit;
                vd.ovf = shadow_ovf;
                expected_verdicts.push_back(vd);
            end
            default: ;                               // unknown operation
        endcase
    endfunction

    // ---------------------------------------------------------------------
    // Sampling at the rising edge: request acceptance first, then results
    // ---------------------------------------------------------------------
    logic req_taken = 1'b0;
    logic rsp_taken = 1'b0;
    verdict_t want;

    always @(posedge clk)
    begin
        cycles++;
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                classify_item(pending_items.pop_front());
                req_taken = 1'b1;
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                rsp_taken = 1'b1;
                if (expected_verdicts.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_SHOWN)
                        $display("unexpected result transaction: tag %h", rsp_ch.tag_out);
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    n_tests++;
                    n_hits += int'(want.hit);
                    n_ovf_seen += int'(want.ovf);
                    if (rsp_ch.tag_out !== want.tag || rsp_ch.in_region !== want.hit ||
                        rsp_ch.table_overflow !== want.ovf)
                    begin
                        errors++;
                        if (errors <= MAX_SHOWN)
                            $display("mismatch: tag %h/%h in_region %b/%b overflow %b/%b (exp/act)",
                                     want.tag, rsp_ch.tag_out, want.hit, rsp_ch.in_region,
                                     want.ovf, rsp_ch.table_overflow);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, expected_verdicts.size());
            $display("tb_point_in_region_classifier_top: errors");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Driver and sink, both updating at the falling edge
    // ---------------------------------------------------------------------
    int unsigned req_gap = 0, rsp_gap = 0;
    logic calm = 1'b0;                               // stretch with no idling

    function automatic int unsigned draw_gap();
        return calm ? 0 : $urandom_range(0, 11);
    endfunction

    always @(negedge clk)
    begin
        if ($urandom_range(0, 60) == 0) calm <= ~calm;
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
        end
        else if (!req_ch.valid || req_taken)
        begin
            if (req_taken)
            begin
                req_taken = 1'b0;
                req_gap = draw_gap();
            end
            if (req_gap > 0)
            begin
                req_gap--;
                req_ch.valid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                req_ch.valid       <= 1'b1;
                req_ch.operation   <= pending_items[0].operation;
                req_ch.region_kind <= pending_items[0].region_kind;
                req_ch.value_0     <= pending_items[0].value[0];
                req_ch.value_1     <= pending_items[0].value[1];
                req_ch.value_2     <= pending_items[0].value[2];
                req_ch.value_3     <= pending_items[0].value[3];
                req_ch.value_4     <= pending_items[0].value[4];
                req_ch.value_5     <= pending_items[0].value[5];
                req_ch.value_6     <= pending_items[0].value[6];
                req_ch.value_7     <= pending_items[0].value[7];
                req_ch.point_tag   <= pending_items[0].point_tag;
            end
            else
            begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Result side stalls a drawn number of cycles before each transaction.
    always @(negedge clk)
    begin
        if (rsp_taken)
        begin
            rsp_taken = 1'b0;
            rsp_gap = draw_gap();
        end
        if (rsp_gap > 0)
        begin
            rsp_gap--;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            rsp_ch.ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------
    logic signed [31:0] anchor [3];                  // first point of the latest random load

    function automatic logic signed [31:0] near_coord();
        return 32'($signed($urandom_range(0, 40 * 65536))) - 32'sd1310720;
    endfunction

    function automatic logic signed [31:0] span(input int unsigned lim);
        return 32'($urandom_range(0, lim * 65536));
    endfunction

    function automatic item_t mk(input logic [1:0] op, input logic [1:0] kind,
                                 input longint v0, input longint v1, input longint v2,
                                 input longint v3, input longint v4, input longint v5,
                                 input longint v6, input longint v7);
        item_t it;
        it.operation = op;
        it.region_kind = kind;
        it.value[0] = v0[31:0]; it.value[1] = v1[31:0];
        it.value[2] = v2[31:0]; it.value[3] = v3[31:0];
        it.value[4] = v4[31:0]; it.value[5] = v5[31:0];
        it.value[6] = v6[31:0]; it.value[7] = v7[31:0];
        it.point_tag = $urandom;
        return it;
    endfunction

    function automatic item_t rand_load();
        item_t it;
        int unsigned kind_pick;
        it = mk(OP_LOAD, KIND_SPHERE, 0, 0, 0, 0, 0, 0, 0, 0);
        for (int k = 0; k < NVAL; k++) it.value[k] = $urandom;   // unused words random
        kind_pick = $urandom_range(0, 2);
        it.region_kind = kind_pick[1:0];
        for (int k = 0; k < 3; k++)
        begin
            it.value[k] = near_coord();
            anchor[k] = it.value[k];
        end
        case (kind_pick)
            0: it.value[3] = span(6) + 1;
            1:
            begin
                it.value[3] = it.value[0] + span(6) + 1;
                it.value[4] = 32'(it.value[1] + span(6) - ONE);  // y span may be empty
                it.value[5] = 32'(it.value[2] + span(6) - ONE);
            end
            default:
            begin
                for (int k = 4; k < 7; k++)
                    it.value[k] = 32'(it.value[k-4] + span(8) - 4 * ONE);
                it.value[3] = span(3);
                it.value[7] = span(3);
            end
        endcase
        // invalid entries and full-range words
        if ($urandom_range(0, 9) == 0)
        begin
            it.value[3] = (kind_pick == 1) ? it.value[0] - span(2) : -span(2);
            if (kind_pick == 2 && $urandom_range(0, 1))
            begin
                it.value[3] = span(2);
                it.value[7] = -span(2) - 1;
            end
        end
        if ($urandom_range(0, 19) == 0)
            for (int k = 0; k < NVAL; k++) it.value[k] = $urandom;
        return it;
    endfunction

    function automatic item_t rand_test();
        item_t it;
        it = mk(OP_TEST, 2'($urandom), 0, 0, 0, $urandom, $urandom, $urandom,
                $urandom, $urandom);
        for (int k = 0; k < 3; k++)
            case ($urandom_range(0, 9))
                0, 1, 2:  it.value[k] = near_coord();
                9:        it.value[k] = $urandom;
                default:  it.value[k] = 32'(anchor[k] + span(6) - 3 * ONE);
            endcase
        return it;
    endfunction

    task automatic drain_and_settle();
        wait (pending_items.size() == 0 && !req_ch.valid);
        wait (expected_verdicts.size() == 0);
        repeat (SETTLE) @(posedge clk);             // a load may still be writing
    endtask

    task automatic write_axis(input logic [1:0] ax);
        drain_and_settle();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= ax;
        @(negedge clk);
        cfg_we <= 1'b0;
        shadow_axis = ax;
    endtask

    int unsigned counted;
    int unsigned n_load_burst;
    logic [1:0] axis_plan [8] = '{2'd1, 2'd2, 2'd3, 2'd0, 2'd3, 2'd1, 2'd0, 2'd2};

    initial
    begin
        req_ch.valid = 1'b0;
        req_ch.operation = OP_TEST;
        req_ch.region_kind = KIND_SPHERE;
        {req_ch.value_0, req_ch.value_1, req_ch.value_2, req_ch.value_3} = '0;
        {req_ch.value_4, req_ch.value_5, req_ch.value_6, req_ch.value_7} = '0;
        req_ch.point_tag = '0;
        rsp_ch.ready = 1'b0;
        anchor = '{0, 0, 0};
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty table, boundaries, invalid loads, odd codes, extremes.
        pending_items.push_back(mk(OP_TEST, KIND_SPHERE, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(mk(OP_LOAD, KIND_SPHERE, 0, 0, 0, ONE, 0, 0, 0, 0));
        pending_items.push_back(mk(OP_TEST, KIND_SPHERE, ONE, 0, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(mk(OP_TEST, KIND_SPHERE, ONE, 1, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(mk(OP_LOAD, KIND_SPHERE, 9 * ONE, 0, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(mk(OP_TEST, KIND_SPHERE, 9 * ONE, 0, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(mk(OP_LOAD, KIND_BOX, 2 * ONE, 2 * ONE, 2 * ONE,
                                   3 * ONE, 3 * ONE, 3 * ONE, -1, -1));
        pending_items.push_back(mk(OP_TEST, KIND_BOX, 3 * ONE, 2 * ONE, 3 * ONE,
                                   0, 0, 0, 0, 0));
        pending_items.push_back(mk(OP_LOAD, KIND_BOX, 5 * ONE, 0, 0, 5 * ONE,
                                   ONE, ONE, 0, 0));
        pending_items.push_back(mk(OP_LOAD, KIND_CONE, -8 * ONE, 0, 0, ONE,
                                   -4 * ONE, 0, 0, 2 * ONE));
        pending_items.push_back(mk(OP_TEST, KIND_CONE, -6 * ONE, ONE, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(mk(OP_TEST, KIND_CONE, -9 * ONE, 0, 0, 0, 0, 0, 0, 0));
        // zero-height cone, negative cone radius, kind 3, operation 3
        pending_items.push_back(mk(OP_LOAD, KIND_CONE, 7 * ONE, 7 * ONE, 7 * ONE, ONE,
                                   7 * ONE, 7 * ONE, 7 * ONE, ONE));
        pending_items.push_back(mk(OP_TEST, KIND_CONE, 7 * ONE, 7 * ONE, 7 * ONE,
                                   0, 0, 0, 0, 0));
        pending_items.push_back(mk(OP_LOAD, KIND_CONE, 0, 0, 0, -1, ONE, 0, 0, ONE));
        pending_items.push_back(mk(OP_LOAD, 2'd3, 0, 0, 0, ONE, ONE, ONE, ONE, ONE));
        pending_items.push_back(mk(2'd3, 2'd3, -1, -1, -1, -1, -1, -1, -1, -1));
        pending_items.push_back(mk(OP_LOAD, KIND_SPHERE, CMIN, CMIN, CMIN, CMAX,
                                   CMAX, CMAX, CMAX, CMAX));
        pending_items.push_back(mk(OP_TEST, KIND_SPHERE, CMAX, CMAX, CMAX, 0, 0, 0, 0, 0));
        pending_items.push_back(mk(OP_LOAD, KIND_CONE, CMIN, CMAX, CMIN, CMAX,
                                   CMAX, CMIN, CMAX, CMAX));
        pending_items.push_back(mk(OP_TEST, KIND_SPHERE, CMIN, CMIN, CMAX, 0, 0, 0, 0, 0));
        pending_items.push_back(mk(OP_CLEAR, KIND_SPHERE, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(mk(OP_TEST, KIND_SPHERE, 0, 0, 0, 0, 0, 0, 0, 0));

        // Random phases, two per mirror plane setting; extremes hit in each plane.
        foreach (axis_plan[ph])
        begin
            write_axis(axis_plan[ph]);
            pending_items.push_back(mk(OP_LOAD, KIND_BOX, CMIN, CMIN, CMIN,
                                       CMAX, CMAX, CMAX, 0, 0));
            pending_items.push_back(mk(OP_TEST, KIND_BOX, CMAX, CMAX, CMAX, 0, 0, 0, 0, 0));
            pending_items.push_back(mk(OP_CLEAR, KIND_BOX, 0, 0, 0, 0, 0, 0, 0, 0));
            counted = 0;
            while (counted < 40)
            begin
                if ($urandom_range(0, 5) == 0)
                begin
                    pending_items.push_back(mk(OP_CLEAR, 2'($urandom), $urandom, 0, 0,
                                               0, 0, 0, 0, $urandom));
                    counted++;
                end
                // occasionally overfill the table
                n_load_burst = ($urandom_range(0, 9) == 0) ? $urandom_range(18, 36)
                                                           : $urandom_range(1, 4);
                repeat (n_load_burst)
                begin
                    pending_items.push_back(rand_load());
                    counted++;
                end
                repeat ($urandom_range(2, 6))
                begin
                    pending_items.push_back(rand_test());
                    counted++;
                end
                if ($urandom_range(0, 7) == 0)
                begin
                    pending_items.push_back(mk(2'd3, 2'($urandom), $urandom, $urandom,
                                               $urandom, 0, 0, 0, 0, $urandom));
                    pending_items.push_back(mk(OP_LOAD, 2'd3, 0, 0, 0, ONE, ONE, ONE,
                                               ONE, ONE));
                end
                wait (pending_items.size() < 8);
            end
        end

        drain_and_settle();
        $display("covered %0d tests (%0d inside a region, %0d with overflow set)",
                 n_tests, n_hits, n_ovf_seen);
        $display("%0d valid loads over all four mirror planes", n_loads);
        if (errors == 0)
            $display("tb_point_in_region_classifier_top: clean");
        else
            $display("tb_point_in_region_classifier_top: errors");
        $finish;
    end

endmodule
`default_nettype wire
